### src/seed_to_permutation_defines.svh
// Assertion macros shared by the seed_to_permutation RTL
`ifndef SEED_TO_PERMUTATION_DEFINES_SVH
`define SEED_TO_PERMUTATION_DEFINES_SVH

// Condition that must hold on every clock edge out of reset
`define STP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define STP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/stp_pkg.sv
// Types and constants shared by the seed_to_permutation modules
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

    // Field widths
    localparam int SEED_W = 32;
    localparam int CNT_W  = 5;
    localparam int VAL_W  = 4;

    // Element count after reset
    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd8;

    // Most results one request may produce
    localparam int RESULT_LIMIT = 16;

    // Divider: quotient bits retired per cycle and steps per division
    localparam int DIGIT_BITS = 8;
    localparam int DIV_STEPS  = SEED_W / DIGIT_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_CHK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT
    } stp_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic start;
        logic init_wr;
        logic k_clr;
        logic div_step;
        logic swap_rd;
        logic wr_a;
        logic wr_b;
        logic next_pos;
        logic emit_rd;
        logic emit_ld;
    } stp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic k_last;
        logic pos_more;
        logic pos_more_next;
        logic digit_zero;
        logic out_free;
    } stp_sts_t;

endpackage

`default_nettype wire

### src/seed_to_permutation.sv
// Top level: seed to permutation unranking, controller plus datapath
//
//   channel   direction  handshake                  payload
//   seed      in         seed_valid / seed_stall    seed[31:0]
//   result    out        result_valid / result_stall position[3:0], value[3:0], last
//   config    in         element_count_wr_en        element_count[4:0]
//
// A request runs the fill, divide, swap and emit steps in order, paced by
// the 8-bit-per-cycle divider, the single memory write port and a
// separate read and load for each result; no new seed is taken until
// the last result is loaded. Results come out one per position, in order.
// rst_n clears control state and sets the element count to 8; the
// permutation memory needs no clearing. A stalled result holds the
// emit sequence while the result register stays full.
`timescale 1ns / 1ps
`default_nettype none

module seed_to_permutation #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       element_count_wr_en,
    input  wire logic [stp_pkg::CNT_W-1:0]  element_count,
    input  wire logic                       seed_valid,
    output logic                            seed_stall,
    input  wire logic [stp_pkg::SEED_W-1:0] seed,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [stp_pkg::VAL_W-1:0]       position,
    output logic [stp_pkg::VAL_W-1:0]       value,
    output logic                            last
);
    import stp_pkg::*;

    // Entries actually stored
    localparam int DEPTH = (MAX_ELEMENTS < RESULT_LIMIT) ? MAX_ELEMENTS : RESULT_LIMIT;

    stp_cmd_t cmd;
    stp_sts_t sts;

    stp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_valid (seed_valid),
        .seed_stall (seed_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    stp_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .element_count_wr_en (element_count_wr_en),
        .element_count       (element_count),
        .seed                (seed),
        .result_stall        (result_stall),
        .result_valid        (result_valid),
        .position            (position),
        .value               (value),
        .last                (last)
    );

endmodule

`default_nettype wire

### src/stp_datapath.sv
// Datapath: count register, seed divider, permutation memory, result register
`timescale 1ns / 1ps
`default_nettype none

`include "seed_to_permutation_defines.svh"

module stp_datapath #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stp_pkg::stp_cmd_t          cmd,
    output stp_pkg::stp_sts_t               sts,
    input  wire logic                       element_count_wr_en,
    input  wire logic [stp_pkg::CNT_W-1:0]  element_count,
    input  wire logic [stp_pkg::SEED_W-1:0] seed,
    input  wire logic                       result_stall,
    output logic                            result_valid,
    output logic [stp_pkg::VAL_W-1:0]       position,
    output logic [stp_pkg::VAL_W-1:0]       value,
    output logic                            last
);
    import stp_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  n_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     k_reg;
    logic [SEED_W-1:0] acc_reg;
    logic [SEED_W-1:0] acc_next;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [CNT_W-1:0]  radix;
    logic [CNT_W-1:0]  dest_full;
    logic [IW-1:0]     dest;
    logic [CNT_W-1:0]  div_r;
    logic [CNT_W:0]    div_t;
    logic [DIGIT_BITS-1:0] div_q;
    logic [VAL_W-1:0]  store [DEPTH];
    logic [VAL_W-1:0]  rd_a_reg;
    logic [VAL_W-1:0]  rd_b_reg;
    logic              result_valid_reg;
    logic [VAL_W-1:0]  position_reg;
    logic [VAL_W-1:0]  value_reg;
    logic              last_reg;

    // Element count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (element_count_wr_en)
        begin
            count_reg <= element_count;
        end
    end

    // Count in use: zero reads as one, saturate at the store depth
    always_comb
    begin
        priority if (count_reg == '0)
            eff_count = CNT_W'(1);
        else if (count_reg > DEPTH_CNT)
            eff_count = DEPTH_CNT;
        else
            eff_count = count_reg;
    end

    assign radix     = n_reg - CNT_W'(i_reg);
    assign dest_full = CNT_W'(i_reg) + rem_reg;
    assign dest      = dest_full[IW-1:0];

    // Restoring divider, DIGIT_BITS quotient bits per step
    always_comb
    begin
        div_r = rem_reg;
        div_q = '0;
        div_t = '0;
        for (int j = 0; j < DIGIT_BITS; j++)
        begin
            div_t = {div_r, acc_reg[SEED_W-1-j]};
            if (div_t >= {1'b0, radix})
            begin
                div_r = CNT_W'(div_t - {1'b0, radix});
                div_q[DIGIT_BITS-1-j] = 1'b1;
            end
            else
            begin
                div_r = div_t[CNT_W-1:0];
            end
        end
        rem_next = div_r;
        acc_next = {acc_reg[SEED_W-DIGIT_BITS-1:0], div_q};
    end

    // Sequencing registers: count, position, counter, seed, remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= CNT_W'(1);
            i_reg   <= '0;
            k_reg   <= '0;
            acc_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                n_reg   <= eff_count;
                acc_reg <= seed;
            end
            else if (cmd.div_step)
            begin
                acc_reg <= acc_next;
            end

            priority if (cmd.start || cmd.next_pos)
                rem_reg <= '0;
            else if (cmd.div_step)
                rem_reg <= rem_next;

            priority if (cmd.start)
                i_reg <= '0;
            else if (cmd.next_pos)
                i_reg <= i_reg + IW'(1);

            priority if (cmd.start || cmd.k_clr)
                k_reg <= '0;
            else if (cmd.init_wr || cmd.emit_ld)
                k_reg <= k_reg + IW'(1);
        end
    end

    // Permutation memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        priority if (cmd.init_wr)
            store[k_reg] <= VAL_W'(k_reg);
        else if (cmd.wr_a)
            store[dest] <= rd_a_reg;
        else if (cmd.wr_b)
            store[i_reg] <= rd_b_reg;

        priority if (cmd.swap_rd)
        begin
            rd_a_reg <= store[i_reg];
            rd_b_reg <= store[dest];
        end
        else if (cmd.emit_rd)
        begin
            rd_a_reg <= store[k_reg];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ld)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ld)
        begin
            position_reg <= VAL_W'(k_reg);
            value_reg    <= rd_a_reg;
            last_reg     <= sts.k_last;
        end
    end

    // Status
    assign sts.k_last        = (CNT_W'(k_reg) == n_reg - CNT_W'(1));
    assign sts.pos_more      = (CNT_W'(i_reg) + CNT_W'(1) < n_reg);
    assign sts.pos_more_next = (CNT_W'(i_reg) + CNT_W'(2) < n_reg);
    assign sts.digit_zero    = (rem_reg == '0);
    assign sts.out_free      = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign position     = position_reg;
    assign value        = value_reg;
    assign last         = last_reg;

    // Checks
    `STP_ASSERT_IMPLIES(a_digit_below_radix, cmd.swap_rd, rem_reg < radix, "digit not below radix")
    `STP_ASSERT_IMPLIES(a_swap_in_range, cmd.wr_a, (dest_full > CNT_W'(i_reg)) && (dest_full < n_reg), "swap target out of range")

endmodule

`default_nettype wire

### src/stp_ctrl.sv
// Controller: sequences fill, divide, swap and emit steps for one request
`timescale 1ns / 1ps
`default_nettype none

`include "seed_to_permutation_defines.svh"

module stp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              seed_valid,
    output logic                   seed_stall,
    input  wire stp_pkg::stp_sts_t sts,
    output stp_pkg::stp_cmd_t      cmd
);
    import stp_pkg::*;

    stp_state_t           state_reg;
    stp_state_t           state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    // State and divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        seed_stall   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                seed_stall = 1'b0;
                if (seed_valid)
                begin
                    cmd.start    = 1'b1;
                    div_cnt_next = '0;
                    state_next   = ST_INIT;
                end
            end

            // write the identity, one entry a cycle
            ST_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (sts.k_last)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = sts.pos_more ? ST_DIV : ST_EMIT_RD;
                end
            end

            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_CHK;
                end
            end

            // digit ready: read both entries, skip the swap on zero
            ST_CHK:
            begin
                cmd.swap_rd = 1'b1;
                if (sts.digit_zero)
                begin
                    cmd.next_pos = 1'b1;
                    state_next   = sts.pos_more_next ? ST_DIV : ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_SWAP_A;
                end
            end

            ST_SWAP_A:
            begin
                cmd.wr_a   = 1'b1;
                state_next = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                cmd.wr_b     = 1'b1;
                cmd.next_pos = 1'b1;
                state_next   = sts.pos_more_next ? ST_DIV : ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT;
            end

            // hold the read data until the result register frees up
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = sts.k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks
    `STP_ASSERT_ALWAYS(a_one_mem_write, $onehot0({cmd.init_wr, cmd.wr_a, cmd.wr_b}), "more than one memory write")

endmodule

`default_nettype wire
